// File: rtl/ofp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ofp_pkg;

    localparam int CNT_W = 5;

    localparam logic [7:0]       START_BYTE  = 8'hFE;
    localparam logic [7:0]       LEN_BYTE    = 8'h1A;
    localparam logic [7:0]       MSG_ID_FLOW = 8'd100;
    localparam logic [CNT_W-1:0] HEADER_LEN  = 5'd4;
    localparam logic [CNT_W-1:0] PAYLOAD_LEN = 5'd26;
    localparam int               PAYLOAD_N   = 26;
    localparam int               HEADER_N    = 4;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_HDR  = 3'd2,
        PH_PAY  = 3'd3
    } t_phase;

    typedef struct packed {
        logic [63:0]        time_usec;
        logic [31:0]        comp_x_bits;
        logic [31:0]        comp_y_bits;
        logic [31:0]        distance_bits;
        logic signed [15:0] flow_x;
        logic signed [15:0] flow_y;
        logic [7:0]         sensor_id;
        logic [7:0]         quality;
        logic [7:0]         seq_number;
        logic [7:0]         system_id;
        logic [7:0]         component_id;
    } t_record;

    typedef struct packed {
        logic emit;
        logic will_emit;
    } t_core_stat;

endpackage
`default_nettype wire

// File: rtl/optical_flow_frame_parser.sv
// The record is presented on o_rec_valid in the cycle after the last payload byte is taken.
// Throughput: one byte per cycle; o_rx_ready drops only when the last payload byte
// is waiting while a previous record is still held on the output register.
// Reset (synchronous, active low): parser returns to hunting for the start byte,
// any pending record is dropped.
`timescale 1ns / 1ps
`default_nettype none
module optical_flow_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_rec_valid,
    input  wire logic        i_rec_ready,
    output logic [63:0]      o_time_usec,
    output logic [31:0]      o_comp_x_bits,
    output logic [31:0]      o_comp_y_bits,
    output logic [31:0]      o_distance_bits,
    output logic signed [15:0] o_flow_x,
    output logic signed [15:0] o_flow_y,
    output logic [7:0]       o_sensor_id,
    output logic [7:0]       o_quality,
    output logic [7:0]       o_seq_number,
    output logic [7:0]       o_system_id,
    output logic [7:0]       o_component_id
);
    import ofp_pkg::*;

    t_core_stat core_stat;
    t_record    core_rec;
    t_record    r_rec;
    logic       r_valid;
    logic       take;

    assign o_rx_ready = !(core_stat.will_emit && r_valid && !i_rec_ready);
    assign take       = i_rx_valid && o_rx_ready;

    ofp_parse_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .o_stat    (core_stat),
        .o_rec     (core_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (core_stat.emit) begin
            r_valid <= 1'b1;
        end else if (i_rec_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_stat.emit) begin
            r_rec <= core_rec;
        end
    end

    assign o_rec_valid     = r_valid;
    assign o_time_usec     = r_rec.time_usec;
    assign o_comp_x_bits   = r_rec.comp_x_bits;
    assign o_comp_y_bits   = r_rec.comp_y_bits;
    assign o_distance_bits = r_rec.distance_bits;
    assign o_flow_x        = r_rec.flow_x;
    assign o_flow_y        = r_rec.flow_y;
    assign o_sensor_id     = r_rec.sensor_id;
    assign o_quality       = r_rec.quality;
    assign o_seq_number    = r_rec.seq_number;
    assign o_system_id     = r_rec.system_id;
    assign o_component_id  = r_rec.component_id;

endmodule
`default_nettype wire

// File: rtl/ofp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
module ofp_parse_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [7:0]       i_rx_byte,
    output ofp_pkg::t_core_stat   o_stat,
    output ofp_pkg::t_record      o_rec
);
    import ofp_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_hdr [HEADER_N];
    logic [7:0]       r_pay [PAYLOAD_N];
    logic             hdr_we, pay_we;
    logic [CNT_W-1:0] pay_idx;
    logic             id_ok;
    logic             emit;

    assign id_ok = (r_hdr[3] == MSG_ID_FLOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_count[1:0]] <= i_rx_byte;
        end
        if (pay_we) begin
            r_pay[pay_idx] <= i_rx_byte;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        hdr_we  = 1'b0;
        pay_we  = 1'b0;
        pay_idx = r_count;
        emit    = 1'b0;
        if (i_take) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == START_BYTE) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_phase = (i_rx_byte == LEN_BYTE) ? PH_HDR : PH_HUNT;
                end
                PH_HDR: begin
                    if (r_count < HEADER_LEN) begin
                        hdr_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        pay_we  = 1'b1;
                        pay_idx = '0;
                        n_count = 5'd1;
                        n_phase = PH_PAY;
                    end
                end
                PH_PAY: begin
                    if (!id_ok || r_count == '0 || r_count >= PAYLOAD_LEN) begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                    end else if (r_count == PAYLOAD_LEN - 1'b1) begin
                        emit    = 1'b1;
                        n_phase = PH_HUNT;
                        n_count = '0;
                    end else begin
                        pay_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_count = '0;
                end
            endcase
        end
    end

    // last payload byte is taken straight from the input
    always_comb begin
        o_rec.time_usec     = {r_pay[7], r_pay[6], r_pay[5], r_pay[4],
                               r_pay[3], r_pay[2], r_pay[1], r_pay[0]};
        o_rec.comp_x_bits   = {r_pay[11], r_pay[10], r_pay[9], r_pay[8]};
        o_rec.comp_y_bits   = {r_pay[15], r_pay[14], r_pay[13], r_pay[12]};
        o_rec.distance_bits = {r_pay[19], r_pay[18], r_pay[17], r_pay[16]};
        o_rec.flow_x        = {r_pay[21], r_pay[20]};
        o_rec.flow_y        = {r_pay[23], r_pay[22]};
        o_rec.sensor_id     = r_pay[24];
        o_rec.quality       = i_rx_byte;
        o_rec.seq_number    = r_hdr[0];
        o_rec.system_id     = r_hdr[1];
        o_rec.component_id  = r_hdr[2];
    end

    assign o_stat.emit      = emit;
    assign o_stat.will_emit = (r_phase == PH_PAY) && id_ok
                              && (r_count == PAYLOAD_LEN - 1'b1);

endmodule
`default_nettype wire

// File: rtl/ofp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ofp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_rx_valid,
    input wire logic        o_rx_ready,
    input wire logic        o_rec_valid,
    input wire logic        i_rec_ready,
    input wire logic [63:0] o_time_usec,
    input wire logic [7:0]  o_quality
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rec_valid)
        else $error("record valid after reset");

    a_rise_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rec_valid) |-> $past(i_rx_valid && o_rx_ready))
        else $error("record appeared without an accepted request");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid && !i_rec_ready |=> o_rec_valid)
        else $error("record dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid && !i_rec_ready |=> $stable(o_time_usec) && $stable(o_quality))
        else $error("record changed while stalled");

endmodule

bind optical_flow_frame_parser ofp_checker u_ofp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx_valid),
    .o_rx_ready  (o_rx_ready),
    .o_rec_valid (o_rec_valid),
    .i_rec_ready (i_rec_ready),
    .o_time_usec (o_time_usec),
    .o_quality   (o_quality)
);
`default_nettype wire
